@@ src/mhrq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mhrq_pkg
// Shared widths, types and codes for the min-heap reorder queue.
// ----------------------------------------------------------------------------
package mhrq_pkg;

  localparam int DEPTH   = 64;
  localparam int KEY_W   = 32;
  localparam int SLOT_W  = 8;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = ADDR_W + 2;
  localparam int ENTRY_W = KEY_W + SLOT_W;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_ROOT,
    S_LAST,
    S_DOWN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
  } entry_t;

  typedef struct packed {
    logic              mode;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [KEY_W-1:0]  popped_key;
    logic [SLOT_W-1:0] popped_slot;
    logic [CNT_W-1:0]  entry_count;
    logic              head_valid;
    logic [KEY_W-1:0]  head_key;
    logic [SLOT_W-1:0] head_slot;
  } res_t;

endpackage
`default_nettype wire

@@ src/mhrq_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mhrq channel interfaces
// Valid/ready channels for requests, results and the capacity register.
// ----------------------------------------------------------------------------
interface mhrq_in_if import mhrq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [KEY_W-1:0]  key_in;
  logic [SLOT_W-1:0] slot_in;

  modport source (output valid, mode, key_in, slot_in, input ready);
  modport sink   (input valid, mode, key_in, slot_in, output ready);
endinterface

interface mhrq_out_if import mhrq_pkg::*; ();
  logic              valid;
  logic              ready;
  status_t           status;
  logic [KEY_W-1:0]  popped_key;
  logic [SLOT_W-1:0] popped_slot;
  logic [CNT_W-1:0]  entry_count;
  logic              head_valid;
  logic [KEY_W-1:0]  head_key;
  logic [SLOT_W-1:0] head_slot;

  modport source (output valid, status, popped_key, popped_slot, entry_count,
                  head_valid, head_key, head_slot, input ready);
  modport sink   (input valid, status, popped_key, popped_slot, entry_count,
                  head_valid, head_key, head_slot, output ready);
endinterface

interface mhrq_cfg_if import mhrq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] capacity_in_use;

  modport source (output valid, capacity_in_use, input ready);
  modport sink   (input valid, capacity_in_use, output ready);
endinterface
`default_nettype wire

@@ src/mhrq_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mhrq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mhrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire [$clog2(DEPTH)-1:0]   raddr_a,
  output logic [WIDTH-1:0]          rdata_a,
  input  wire [$clog2(DEPTH)-1:0]   raddr_b,
  output logic [WIDTH-1:0]          rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

@@ src/mhrq_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mhrq_ctrl
// Sift-up / sift-down sequencer over the heap RAM, with head and count.
// ----------------------------------------------------------------------------
module mhrq_ctrl import mhrq_pkg::*; (
  input  wire              clk,
  input  wire              rst_n,
  input  wire [CNT_W-1:0]  cap,
  input  wire              req_valid,
  output logic             req_ready,
  input  req_t             req,
  output logic             res_valid,
  input  wire              res_ready,
  output res_t             res
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  entry_t            head_r, head_nxt;
  entry_t            ent_r, ent_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  status_t           status_r, status_nxt;
  logic [KEY_W-1:0]  pkey_r, pkey_nxt;
  logic [SLOT_W-1:0] pslot_r, pslot_nxt;

  logic                we;
  logic [ADDR_W-1:0]   waddr;
  entry_t              wdata;
  logic [ADDR_W-1:0]   raddr_a, raddr_b;
  logic [ENTRY_W-1:0]  rdata_a, rdata_b;
  entry_t              rd_l, rd_r;

  logic [ADDR_W-1:0] par, par2, push_pos, push_par, dn_pos;
  logic [IDX_W-1:0]  lc, rc, cnt_ext;
  logic              take_l, take_r;
  logic [KEY_W-1:0]  best_key;
  logic [IDX_W-1:0]  dn_lc, dn_rc;

  mhrq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  assign rd_l     = entry_t'(rdata_a);
  assign rd_r     = entry_t'(rdata_b);
  assign par      = (pos_r - ADDR_W'(1)) >> 1;
  assign par2     = (par - ADDR_W'(1)) >> 1;
  assign push_pos = count_r[ADDR_W-1:0];
  assign push_par = (push_pos - ADDR_W'(1)) >> 1;
  assign lc       = IDX_W'({pos_r, 1'b1});
  assign rc       = IDX_W'({pos_r, 1'b0}) + IDX_W'(2);
  assign cnt_ext  = IDX_W'(count_r);
  assign take_l   = (lc < cnt_ext) && (rd_l.key < ent_r.key);
  assign best_key = take_l ? rd_l.key : ent_r.key;
  assign take_r   = (rc < cnt_ext) && (rd_r.key < best_key);
  assign dn_pos   = take_r ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];
  assign dn_lc    = IDX_W'({dn_pos, 1'b1});
  assign dn_rc    = IDX_W'({dn_pos, 1'b0}) + IDX_W'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    head_r   <= head_nxt;
    ent_r    <= ent_nxt;
    pos_r    <= pos_nxt;
    status_r <= status_nxt;
    pkey_r   <= pkey_nxt;
    pslot_r  <= pslot_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    head_nxt   = head_r;
    ent_nxt    = ent_r;
    pos_nxt    = pos_r;
    status_nxt = status_r;
    pkey_nxt   = pkey_r;
    pslot_nxt  = pslot_r;
    we         = 1'b0;
    waddr      = pos_r;
    wdata      = ent_r;
    raddr_a    = '0;
    raddr_b    = '0;
    req_ready  = (state_r == S_IDLE);
    res_valid  = (state_r == S_DONE);

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          status_nxt = ST_DONE;
          pkey_nxt   = '0;
          pslot_nxt  = '0;
          if (req.mode == MODE_PUSH) begin
            if (count_r >= cap) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              ent_nxt   = '{key: req.key, slot: req.slot};
              pos_nxt   = push_pos;
              count_nxt = count_r + CNT_W'(1);
              if (count_r == '0) begin
                we        = 1'b1;
                waddr     = '0;
                wdata     = '{key: req.key, slot: req.slot};
                head_nxt  = '{key: req.key, slot: req.slot};
                state_nxt = S_DONE;
              end else begin
                raddr_a   = push_par;
                state_nxt = S_UP;
              end
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              pkey_nxt  = head_r.key;
              pslot_nxt = head_r.slot;
              count_nxt = count_r - CNT_W'(1);
              raddr_a   = push_pos - ADDR_W'(1);
              state_nxt = S_LAST;
            end
          end
        end
      end
      S_UP: begin
        we = 1'b1;
        if (ent_r.key >= rd_l.key) begin
          state_nxt = S_DONE;
        end else begin
          wdata   = rd_l;
          pos_nxt = par;
          if (par == '0) begin
            state_nxt = S_ROOT;
          end else begin
            raddr_a = par2;
          end
        end
      end
      S_ROOT: begin
        we        = 1'b1;
        waddr     = '0;
        head_nxt  = ent_r;
        state_nxt = S_DONE;
      end
      S_LAST: begin
        ent_nxt = rd_l;
        if (count_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          pos_nxt   = '0;
          raddr_a   = ADDR_W'(1);
          raddr_b   = ADDR_W'(2);
          state_nxt = S_DOWN;
        end
      end
      S_DOWN: begin
        we = 1'b1;
        if (take_l || take_r) begin
          wdata   = take_r ? rd_r : rd_l;
          if (pos_r == '0) begin
            head_nxt = take_r ? rd_r : rd_l;
          end
          pos_nxt = dn_pos;
          raddr_a = dn_lc[ADDR_W-1:0];
          raddr_b = dn_rc[ADDR_W-1:0];
        end else begin
          if (pos_r == '0) begin
            head_nxt = ent_r;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.status      = status_r;
    res.popped_key  = pkey_r;
    res.popped_slot = pslot_r;
    res.entry_count = count_r;
    res.head_valid  = (count_r != '0);
    res.head_key    = (count_r != '0) ? head_r.key : '0;
    res.head_slot   = (count_r != '0) ? head_r.slot : '0;
  end

endmodule
`default_nettype wire

@@ src/min_heap_reorder_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// min_heap_reorder_queue
// Binary min-heap priority queue keyed by sequence number.
// ----------------------------------------------------------------------------
// Result: a dropped push, an empty pop or a push into an empty heap goes straight
//   to the result; a push climbs levels in S_UP, a pop sinks levels in S_DOWN.
// Flow: one transaction at a time; each heap level costs one RAM read and
//   write-back.
// Reset: count cleared, capacity set to 64; heap RAM content is not cleared.
module min_heap_reorder_queue import mhrq_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  mhrq_in_if.sink     in_ch,
  mhrq_out_if.source  out_ch,
  mhrq_cfg_if.sink    cfg_ch
);

  logic [CNT_W-1:0] cap_r, cap_nxt;
  logic [CNT_W-1:0] cap_eff;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_r, out_nxt;
  req_t             req;
  res_t             res;
  logic             res_valid, res_ready;

  assign cfg_ch.ready = 1'b1;
  assign cap_nxt = (cfg_ch.valid) ? cfg_ch.capacity_in_use : cap_r;
  assign cap_eff = (cap_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_r;

  assign req = '{mode: in_ch.mode, key: in_ch.key_in, slot: in_ch.slot_in};
  assign res_ready = !out_valid_r || out_ch.ready;

  mhrq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap       (cap_eff),
    .req_valid (in_ch.valid),
    .req_ready (in_ch.ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CNT_W'(DEPTH);
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_r.status;
  assign out_ch.popped_key  = out_r.popped_key;
  assign out_ch.popped_slot = out_r.popped_slot;
  assign out_ch.entry_count = out_r.entry_count;
  assign out_ch.head_valid  = out_r.head_valid;
  assign out_ch.head_key    = out_r.head_key;
  assign out_ch.head_slot   = out_r.head_slot;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted while a transaction is in flight");

  a_pop_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.head_valid |-> out_ch.popped_key <= out_ch.head_key)
    else $error("popped key larger than new head");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.entry_count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_EMPTY
      |-> out_ch.entry_count == '0 && !out_ch.head_valid)
    else $error("empty status with stored entries");

endmodule
`default_nettype wire

@@ tb/mhrq_heap_checker.sv @@
// ----------------------------------------------------------------------------
// mhrq_heap_checker
// Watches the request, result and capacity channels of the min-heap reorder
// queue. It keeps a mirror heap with its own copy of the capacity. For every
// accepted request it works out the reply. Each result transaction is checked,
// field by field, against the oldest reply still owed.
// ----------------------------------------------------------------------------
module mhrq_heap_checker import mhrq_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  mhrq_in_if   in_ch,
  mhrq_out_if  out_ch,
  mhrq_cfg_if  cfg_ch,
  output int   heap_errors,
  output int   replies_owed
);

  entry_t           mirror_heap [DEPTH];
  int unsigned      mirror_fill;
  logic [CNT_W-1:0] mirror_cap;
  res_t             heap_replies [$];

  function automatic void swap_slots(int unsigned a, int unsigned b);
    entry_t t;
    t              = mirror_heap[a];
    mirror_heap[a] = mirror_heap[b];
    mirror_heap[b] = t;
  endfunction

  function automatic res_t heap_op(req_t rq);
    res_t        r;
    int unsigned lim;
    int unsigned pos;
    int unsigned up;
    int unsigned best;
    int unsigned lc;
    int unsigned rc;
    r        = '0;
    r.status = ST_DONE;
    lim      = (mirror_cap > DEPTH) ? DEPTH : mirror_cap;
    if (rq.mode == MODE_PUSH) begin
      if (mirror_fill >= lim) begin
        r.status = ST_FULL;
      end else begin
        mirror_heap[mirror_fill] = {rq.key, rq.slot};
        pos = mirror_fill;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (mirror_heap[pos].key >= mirror_heap[up].key) break;
          swap_slots(pos, up);
          pos = up;
        end
        mirror_fill++;
      end
    end else if (mirror_fill == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.popped_key   = mirror_heap[0].key;
      r.popped_slot  = mirror_heap[0].slot;
      mirror_fill--;
      mirror_heap[0] = mirror_heap[mirror_fill];
      pos = 0;
      while (1'b1) begin
        best = pos;
        lc   = 2 * pos + 1;
        rc   = 2 * pos + 2;
        if (lc < mirror_fill && mirror_heap[lc].key < mirror_heap[best].key) best = lc;
        if (rc < mirror_fill && mirror_heap[rc].key < mirror_heap[best].key) best = rc;
        if (best == pos) break;
        swap_slots(pos, best);
        pos = best;
      end
    end
    r.entry_count = CNT_W'(mirror_fill);
    r.head_valid  = (mirror_fill != 0);
    if (mirror_fill != 0) begin
      r.head_key  = mirror_heap[0].key;
      r.head_slot = mirror_heap[0].slot;
    end
    return r;
  endfunction

  function automatic void check_field(string fld, logic [KEY_W-1:0] want,
                                      logic [KEY_W-1:0] got);
    if (want !== got) begin
      heap_errors++;
      if (heap_errors <= 10)
        $display("mismatch on %s: expected %0h, got %0h", fld, want, got);
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    req_t rq;
    if (!rst_n) begin
      mirror_fill = 0;
      mirror_cap  = CNT_W'(DEPTH);
      heap_replies.delete();
      heap_errors = 0;
      replies_owed <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) mirror_cap = cfg_ch.capacity_in_use;
      if (in_ch.valid && in_ch.ready) begin
        rq.mode = in_ch.mode;
        rq.key  = in_ch.key_in;
        rq.slot = in_ch.slot_in;
        heap_replies.push_back(heap_op(rq));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (heap_replies.size() == 0) begin
          heap_errors++;
          if (heap_errors <= 10)
            $display("result transaction with no request outstanding");
        end else begin
          want = heap_replies.pop_front();
          check_field("status", KEY_W'(want.status), KEY_W'(out_ch.status));
          check_field("popped_key",  want.popped_key,  out_ch.popped_key);
          check_field("popped_slot", KEY_W'(want.popped_slot),
                      KEY_W'(out_ch.popped_slot));
          check_field("entry_count", KEY_W'(want.entry_count),
                      KEY_W'(out_ch.entry_count));
          check_field("head_valid", KEY_W'(want.head_valid),
                      KEY_W'(out_ch.head_valid));
          check_field("head_key",    want.head_key,    out_ch.head_key);
          check_field("head_slot", KEY_W'(want.head_slot),
                      KEY_W'(out_ch.head_slot));
        end
      end
      replies_owed <= heap_replies.size();
    end
  end

endmodule

@@ tb/tb_min_heap_reorder_queue.sv @@
// ----------------------------------------------------------------------------
// tb_min_heap_reorder_queue
// Drives pushes, pops and capacity writes into the min-heap reorder queue:
// a short directed run over extremes, equal keys, full and empty heaps, then
// randomized phases with varied capacity, input gaps and output back-pressure.
// Checking lives in mhrq_heap_checker.
// ----------------------------------------------------------------------------
module tb_min_heap_reorder_queue;
  import mhrq_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 180;
  localparam int SETTLE_CYCLES = 12;

  logic clk = 1'b0;
  logic rst_n;
  int   gap_pct;
  int   stall_pct;
  int   quiet_cycles = 0;
  int   heap_errors;
  int   replies_owed;

  mhrq_in_if  in_ch ();
  mhrq_out_if out_ch ();
  mhrq_cfg_if cfg_ch ();

  min_heap_reorder_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  mhrq_heap_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .heap_errors  (heap_errors),
    .replies_owed (replies_owed)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("min_heap_reorder_queue verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 3))
      0:       k = KEY_W'($urandom_range(0, 15));
      1:       k = {KEY_W{$urandom_range(0, 1) == 1}} ^ KEY_W'($urandom_range(0, 3));
      default: k = KEY_W'($urandom);
    endcase
    return k;
  endfunction

  task automatic issue(input logic mode, input logic [KEY_W-1:0] key,
                       input logic [SLOT_W-1:0] slot);
    int gap;
    gap = 0;
    while (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= mode;
    in_ch.key_in  <= key;
    in_ch.slot_in <= slot;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // hold off until every reply is back, then let the block go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (replies_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input int cap);
    settle();
    cfg_ch.valid           <= 1'b1;
    cfg_ch.capacity_in_use <= CNT_W'(cap);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int push_pct;
    int cap;
    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.mode             = MODE_PUSH;
    in_ch.key_in           = '0;
    in_ch.slot_in          = '0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.capacity_in_use = CNT_W'(DEPTH);
    gap_pct                = 0;
    stall_pct              = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(MODE_POP,  '0, '0);
    issue(MODE_PUSH, '1, '1);
    issue(MODE_PUSH, '0, 8'h00);
    issue(MODE_PUSH, '0, 8'h01);
    issue(MODE_PUSH, 32'd7, 8'hAA);
    issue(MODE_PUSH, 32'd7, 8'h55);
    issue(MODE_PUSH, 32'd7, 8'h0F);
    issue(MODE_PUSH, 32'h8000_0000, 8'h80);
    issue(MODE_PUSH, 32'h0000_0001, 8'h01);
    repeat (8) issue(MODE_POP, '1, '1);
    issue(MODE_POP, '0, '0);

    set_capacity(1);
    issue(MODE_PUSH, 32'h5555_5555, 8'h03);
    issue(MODE_PUSH, 32'h0000_0006, 8'h04);
    issue(MODE_POP,  '0, '0);
    issue(MODE_POP,  '0, '0);

    set_capacity(0);
    issue(MODE_PUSH, 32'hAAAA_AAAA, 8'hFE);
    issue(MODE_POP,  '0, '0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin cap = DEPTH; push_pct = 85; end
        1:       begin cap = 127;   push_pct = 80; end
        2:       begin cap = 3;     push_pct = 30; end
        3:       begin cap = 0;     push_pct = 50; end
        4:       begin cap = 1;     push_pct = 50; end
        5:       begin cap = 100;   push_pct = 60; end
        6:       begin cap = DEPTH; push_pct = 55; end
        default: begin cap = 2;     push_pct = 20; end
      endcase
      set_capacity(cap);
      case (p % 4)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 71; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 71; end
        default: begin gap_pct = 7;  stall_pct = 7;  end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < push_pct)
          issue(MODE_PUSH, pick_key(), SLOT_W'($urandom));
        else
          issue(MODE_POP, pick_key(), SLOT_W'($urandom));
      end
    end

    settle();
    if (heap_errors == 0 && replies_owed == 0) begin
      $display("min_heap_reorder_queue verification clean");
    end else begin
      $display("min_heap_reorder_queue verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/mhrq_pkg.sv
src/mhrq_ifs.sv
src/mhrq_ram.sv
src/mhrq_ctrl.sv
src/min_heap_reorder_queue.sv
tb/mhrq_heap_checker.sv
tb/tb_min_heap_reorder_queue.sv
